// ===== rtl/mcht_pkg.sv =====
// ----------------------------------------------------------------------------
// Monotone convex hull trick package
// Shared widths, operation codes, status codes and controller/datapath types.
// ----------------------------------------------------------------------------
package mcht_pkg;

    localparam int LineDepthDefault = 1024;

    localparam int InterceptWidth = 48;
    localparam int SlopeWidth     = 24;
    localparam int ValueWidth     = 49;
    localparam int DiffIWidth     = 49;
    localparam int DiffSWidth     = 25;
    localparam int ProdWidth      = DiffIWidth + DiffSWidth;

    // Split of the intercept difference for the two-step product.
    localparam int MulLoWidth     = 25;
    localparam int MulPartWidth   = MulLoWidth + 1 + DiffSWidth;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Read port selection for the line store.
    localparam logic [2:0] RD_BACK1 = 3'd0;
    localparam logic [2:0] RD_BACK2 = 3'd1;
    localparam logic [2:0] RD_BACK3 = 3'd2;
    localparam logic [2:0] RD_FRONT = 3'd3;
    localparam logic [2:0] RD_NEXT  = 3'd4;

    typedef struct packed {
        logic       clear;      // empty the store
        logic       write_new;  // write the input line at the back
        logic       load_x;     // latch the query abscissa
        logic       rd_en;      // issue a store read
        logic [2:0] rd_sel;     // which slot to read
        logic       cap_a;      // latch read data as line a (or front)
        logic       cap_b;      // latch read data as line b (or next)
        logic       cap_c;      // latch read data as line c
        logic       mul1;       // work on the first product pair
        logic       mul2;       // work on the second product pair
        logic       mul_hi;     // upper half of the current product pair
        logic       prune;      // drop line b (copy c into its slot)
        logic       pop_front;  // advance the front pointer
        logic       eval_front; // evaluate captured front line at x
        logic       eval_next;  // evaluate captured next line at x
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic ge3;
        logic ge2;
        logic keep;     // both hull tests pass
        logic next_gt;  // next line value strictly greater
    } t_stat;

endpackage

// ===== rtl/mcht_if.sv =====
// ----------------------------------------------------------------------------
// Monotone convex hull trick channel interfaces
// Valid/ready channels for the operation input and the result output.
// ----------------------------------------------------------------------------
interface mcht_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic signed [47:0] new_intercept;
    logic signed [23:0] new_slope;
    logic signed [23:0] query_x;

    modport source (output valid, opcode, new_intercept, new_slope, query_x, input ready);
    modport sink   (input valid, opcode, new_intercept, new_slope, query_x, output ready);
endinterface

interface mcht_out_if;
    logic        valid;
    logic        ready;
    logic signed [48:0] best_value;
    logic [1:0]  status;
    logic [10:0] line_count;

    modport source (output valid, best_value, status, line_count, input ready);
    modport sink   (input valid, best_value, status, line_count, output ready);
endinterface

// ===== rtl/mcht_datapath.sv =====
// ----------------------------------------------------------------------------
// Monotone convex hull trick datapath
// Line store, deque pointers, hull test multipliers and line evaluation.
// ----------------------------------------------------------------------------
module mcht_datapath #(
    parameter int LINE_DEPTH = mcht_pkg::LineDepthDefault,
    parameter int PW = $clog2(LINE_DEPTH),
    parameter int CW = $clog2(LINE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcht_pkg::t_cmd     i_cmd,
    input  logic signed [47:0] i_new_intercept,
    input  logic signed [23:0] i_new_slope,
    input  logic signed [23:0] i_query_x,
    output mcht_pkg::t_stat    o_stat,
    output logic signed [48:0] o_value,
    output logic [CW-1:0]      o_count
);

    localparam int DiffIWidth = mcht_pkg::DiffIWidth;
    localparam int DiffSWidth = mcht_pkg::DiffSWidth;
    localparam int ProdWidth  = mcht_pkg::ProdWidth;
    localparam int LoWidth    = mcht_pkg::MulLoWidth;
    localparam int PartWidth  = mcht_pkg::MulPartWidth;

    logic signed [47:0] r_mem_i [LINE_DEPTH];
    logic signed [23:0] r_mem_s [LINE_DEPTH];

    logic [PW-1:0] r_front, r_back;
    logic [CW-1:0] r_count;

    logic signed [47:0] r_rd_i;
    logic signed [23:0] r_rd_s;

    logic signed [47:0] r_ai, r_bi, r_ci;
    logic signed [23:0] r_as, r_bs, r_cs;
    logic signed [23:0] r_x;

    logic signed [ProdWidth-1:0] r_p1, r_p2;
    logic r_t1;
    logic keep;
    logic signed [48:0] r_fv, r_nv;

    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic signed [47:0] wr_i;
    logic signed [23:0] wr_s;
    logic wr_en;

    logic signed [DiffIWidth-1:0] d_ba, d_ca, d_cb;
    logic signed [DiffSWidth-1:0] s_ac, s_ab, s_bc;
    logic signed [DiffIWidth-1:0] mx_d, my_d;
    logic signed [DiffSWidth-1:0] mx_s, my_s;
    logic signed [LoWidth:0]      mx_dig, my_dig;
    logic signed [PartWidth-1:0]  mx_part, my_part;
    logic signed [48:0] eval_v;
    logic signed [47:0] ev_prod;
    logic signed [47:0] ev_i;
    logic signed [23:0] ev_s;

    always_comb begin
        unique case (i_cmd.rd_sel)
            mcht_pkg::RD_BACK1: rd_addr = r_back - PW'(1);
            mcht_pkg::RD_BACK2: rd_addr = r_back - PW'(2);
            mcht_pkg::RD_BACK3: rd_addr = r_back - PW'(3);
            mcht_pkg::RD_NEXT:  rd_addr = r_front + PW'(1);
            default:            rd_addr = r_front;
        endcase
    end

    // LINE_DEPTH is a power of two so the pointers wrap naturally.
    assign wr_en   = i_cmd.write_new | i_cmd.prune;
    assign wr_addr = i_cmd.write_new ? r_back : r_back - PW'(2);
    assign wr_i    = i_cmd.write_new ? i_new_intercept : r_ci;
    assign wr_s    = i_cmd.write_new ? i_new_slope : r_cs;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_i[wr_addr] <= wr_i;
            r_mem_s[wr_addr] <= wr_s;
        end
        if (i_cmd.rd_en) begin
            r_rd_i <= r_mem_i[rd_addr];
            r_rd_s <= r_mem_s[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.write_new) begin
                r_back  <= r_back + PW'(1);
                r_count <= r_count + CW'(1);
            end else if (i_cmd.prune) begin
                r_back  <= r_back - PW'(1);
                r_count <= r_count - CW'(1);
            end else if (i_cmd.pop_front) begin
                r_front <= r_front + PW'(1);
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign d_ba = DiffIWidth'(r_bi) - DiffIWidth'(r_ai);
    assign d_ca = DiffIWidth'(r_ci) - DiffIWidth'(r_ai);
    assign d_cb = DiffIWidth'(r_ci) - DiffIWidth'(r_bi);
    assign s_ac = DiffSWidth'(r_as) - DiffSWidth'(r_cs);
    assign s_ab = DiffSWidth'(r_as) - DiffSWidth'(r_bs);
    assign s_bc = DiffSWidth'(r_bs) - DiffSWidth'(r_cs);

    always_comb begin
        if (i_cmd.mul2) begin
            mx_d = d_cb;
            mx_s = s_ac;
            my_d = d_ca;
            my_s = s_bc;
        end else begin
            mx_d = d_ba;
            mx_s = s_ac;
            my_d = d_ca;
            my_s = s_ab;
        end
    end

    // Each product is built in two steps from a 26 by 25 bit multiply: the
    // low 25 bits of the intercept difference as an unsigned digit, then the
    // signed upper 24 bits, whose partial product is shifted and added.
    always_comb begin
        if (i_cmd.mul_hi) begin
            mx_dig = {{2{mx_d[DiffIWidth-1]}}, mx_d[DiffIWidth-1:LoWidth]};
            my_dig = {{2{my_d[DiffIWidth-1]}}, my_d[DiffIWidth-1:LoWidth]};
        end else begin
            mx_dig = {1'b0, mx_d[LoWidth-1:0]};
            my_dig = {1'b0, my_d[LoWidth-1:0]};
        end
    end

    assign mx_part = PartWidth'(mx_dig) * PartWidth'(mx_s);
    assign my_part = PartWidth'(my_dig) * PartWidth'(my_s);

    assign ev_i    = i_cmd.eval_next ? r_bi : r_ai;
    assign ev_s    = i_cmd.eval_next ? r_bs : r_as;
    assign ev_prod = 48'(ev_s) * 48'(r_x);
    assign eval_v  = 49'(ev_i) + 49'(ev_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_ai <= r_rd_i;
            r_as <= r_rd_s;
        end
        if (i_cmd.cap_b) begin
            r_bi <= r_rd_i;
            r_bs <= r_rd_s;
        end
        if (i_cmd.cap_c) begin
            r_ci <= r_rd_i;
            r_cs <= r_rd_s;
        end
        if (i_cmd.load_x) begin
            r_x <= i_query_x;
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            if (i_cmd.mul_hi) begin
                r_p1 <= r_p1 + (ProdWidth'(mx_part) <<< LoWidth);
                r_p2 <= r_p2 + (ProdWidth'(my_part) <<< LoWidth);
            end else begin
                r_p1 <= ProdWidth'(mx_part);
                r_p2 <= ProdWidth'(my_part);
            end
        end
        // The first pair is complete when the second pair starts.
        if (i_cmd.mul2 && !i_cmd.mul_hi) begin
            r_t1 <= (r_p1 >= r_p2);
        end
        if (i_cmd.eval_front) begin
            r_fv <= eval_v;
        end else if (i_cmd.pop_front) begin
            r_fv <= r_nv;
        end
        if (i_cmd.eval_next) begin
            r_nv <= eval_v;
        end
    end

    assign keep = r_t1 && (r_p1 <= r_p2);

    assign o_stat.full    = (r_count >= CW'(LINE_DEPTH));
    assign o_stat.empty   = (r_count == '0);
    assign o_stat.ge3     = (r_count >= CW'(3));
    assign o_stat.ge2     = (r_count >= CW'(2));
    assign o_stat.keep    = keep;
    assign o_stat.next_gt = (r_nv > r_fv);
    assign o_value        = r_fv;
    assign o_count        = r_count;

endmodule

// ===== rtl/mcht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Monotone convex hull trick controller
// Sequences inserts with back pruning, queries with front popping, and clear.
// ----------------------------------------------------------------------------
module mcht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_opcode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_value_sel,
    input  mcht_pkg::t_stat  i_stat,
    output mcht_pkg::t_cmd   o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_IRD1   = 5'd1;
    localparam logic [4:0] S_IRD2   = 5'd2;
    localparam logic [4:0] S_IRD3   = 5'd3;
    localparam logic [4:0] S_ICAP   = 5'd4;
    localparam logic [4:0] S_IMUL1  = 5'd5;
    localparam logic [4:0] S_IMUL1H = 5'd6;
    localparam logic [4:0] S_IMUL2  = 5'd7;
    localparam logic [4:0] S_IMUL2H = 5'd8;
    localparam logic [4:0] S_IDEC   = 5'd9;
    localparam logic [4:0] S_QCAPF  = 5'd10;
    localparam logic [4:0] S_QEVF   = 5'd11;
    localparam logic [4:0] S_QRD    = 5'd12;
    localparam logic [4:0] S_QCAP   = 5'd13;
    localparam logic [4:0] S_QEVAL  = 5'd14;
    localparam logic [4:0] S_QDEC   = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    logic [4:0] r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       r_vsel, n_vsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= mcht_pkg::ST_OK;
            r_vsel   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_vsel   <= n_vsel;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_vsel   = r_vsel;
        o_cmd    = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_status = mcht_pkg::ST_OK;
                    n_vsel   = 1'b0;
                    n_state  = S_OUT;
                    case (i_opcode)
                        mcht_pkg::OP_INSERT: begin
                            if (i_stat.full) begin
                                n_status = mcht_pkg::ST_FULL;
                            end else begin
                                o_cmd.write_new = 1'b1;
                                n_state = S_IRD1;
                            end
                        end
                        mcht_pkg::OP_QUERY: begin
                            if (i_stat.empty) begin
                                n_status = mcht_pkg::ST_EMPTY;
                            end else begin
                                n_vsel       = 1'b1;
                                o_cmd.load_x = 1'b1;
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = mcht_pkg::RD_FRONT;
                                n_state = S_QCAPF;
                            end
                        end
                        mcht_pkg::OP_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_IRD1: begin
                if (!i_stat.ge3) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mcht_pkg::RD_BACK1;
                    n_state = S_IRD2;
                end
            end
            S_IRD2: begin
                o_cmd.cap_c  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mcht_pkg::RD_BACK2;
                n_state = S_IRD3;
            end
            S_IRD3: begin
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mcht_pkg::RD_BACK3;
                n_state = S_ICAP;
            end
            S_ICAP: begin
                o_cmd.cap_a = 1'b1;
                n_state = S_IMUL1;
            end
            S_IMUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_IMUL1H;
            end
            S_IMUL1H: begin
                o_cmd.mul1   = 1'b1;
                o_cmd.mul_hi = 1'b1;
                n_state = S_IMUL2;
            end
            S_IMUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_IMUL2H;
            end
            S_IMUL2H: begin
                o_cmd.mul2   = 1'b1;
                o_cmd.mul_hi = 1'b1;
                n_state = S_IDEC;
            end
            S_IDEC: begin
                if (i_stat.keep) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.prune = 1'b1;
                    n_state = S_IRD1;
                end
            end
            S_QCAPF: begin
                o_cmd.cap_a = 1'b1;
                n_state = S_QEVF;
            end
            S_QEVF: begin
                o_cmd.eval_front = 1'b1;
                n_state = S_QRD;
            end
            S_QRD: begin
                // The line after the front is only examined while two are held.
                if (!i_stat.ge2) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mcht_pkg::RD_NEXT;
                    n_state = S_QCAP;
                end
            end
            S_QCAP: begin
                o_cmd.cap_b = 1'b1;
                n_state = S_QEVAL;
            end
            S_QEVAL: begin
                o_cmd.eval_next = 1'b1;
                n_state = S_QDEC;
            end
            S_QDEC: begin
                if (i_stat.next_gt) begin
                    o_cmd.pop_front = 1'b1;
                    n_state = S_QRD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_status    = r_status;
    assign o_value_sel = r_vsel;

endmodule

// ===== rtl/monotone_convex_hull_trick_unit.sv =====
// ----------------------------------------------------------------------------
// Monotone convex hull trick unit
// Deque of lines with hull pruning on insert and front popping on query.
// ----------------------------------------------------------------------------
// Each accepted beat is one operation and yields one result beat; the block
// takes no new beat until the result beat has left. Clear, unused and
// rejected operations present their result the cycle after acceptance. An
// insert writes the new line, then runs hull tests against the last three
// lines, pruning while a test fails and three lines are held (three reads
// through the single read port of the line store, one capture, four steps
// for the two product pairs, one decision). A query evaluates the front
// line, then pops it while a next line is held and its value is greater.
// LINE_DEPTH must be a power of two.
module monotone_convex_hull_trick_unit #(
    parameter int LINE_DEPTH = mcht_pkg::LineDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mcht_in_if.sink    i_in,
    mcht_out_if.source o_out
);

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    mcht_pkg::t_cmd  cmd;
    mcht_pkg::t_stat stat;
    logic signed [48:0] value;
    logic [CW-1:0] count;
    logic [1:0] status;
    logic vsel;

    mcht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_opcode    (i_in.opcode),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_value_sel (vsel),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mcht_datapath #(.LINE_DEPTH(LINE_DEPTH), .PW(PW), .CW(CW)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_new_intercept (i_in.new_intercept),
        .i_new_slope     (i_in.new_slope),
        .i_query_x       (i_in.query_x),
        .o_stat          (stat),
        .o_value         (value),
        .o_count         (count)
    );

    assign o_out.best_value = vsel ? value : '0;
    assign o_out.status     = status;
    assign o_out.line_count = 11'(count);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(LINE_DEPTH)) else $error("line count over depth");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("input taken during result");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> count == '0) else $error("clear left lines");
`endif

endmodule
